// ----- src/smbsr_pkg.sv -----
// Package for the SMBus sensor register slave: bus event, phase, response
// and command codes, reset words and the CRC-8 byte update for the PEC.
// No dependencies.
package smbsr_pkg;

  // Bus event kinds
  localparam logic [1:0] FN_START = 2'd0;
  localparam logic [1:0] FN_STOP  = 2'd1;
  localparam logic [1:0] FN_WRITE = 2'd2;
  localparam logic [1:0] FN_READ  = 2'd3;

  // Response codes
  localparam logic [1:0] RESP_ACK  = 2'd0;
  localparam logic [1:0] RESP_NACK = 2'd1;
  localparam logic [1:0] RESP_DONE = 2'd2;

  // Transfer phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_HIGH = 3'd2;
  localparam logic [2:0] PH_LOW  = 3'd3;
  localparam logic [2:0] PH_PEC  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_RAW_CH1   = 3'd0;
  localparam logic [2:0] REG_RAW_CH2   = 3'd1;
  localparam logic [2:0] REG_AMBIENT   = 3'd2;
  localparam logic [2:0] REG_OBJ_TEMP1 = 3'd3;
  localparam logic [2:0] REG_OBJ_TEMP2 = 3'd4;

  // Command codes
  localparam logic [7:0] CmdMax       = 8'h3f;
  localparam logic [5:0] CMD_RAW_CH1   = 6'h04;
  localparam logic [5:0] CMD_RAW_CH2   = 6'h05;
  localparam logic [5:0] CMD_AMBIENT   = 6'h06;
  localparam logic [5:0] CMD_OBJ_TEMP1 = 6'h07;
  localparam logic [5:0] CMD_OBJ_TEMP2 = 6'h08;
  localparam logic [5:0] CMD_FIXED0    = 6'h20;
  localparam logic [5:0] CMD_FIXED1    = 6'h21;
  localparam logic [5:0] CMD_FIXED2    = 6'h22;
  localparam logic [5:0] CMD_FIXED3    = 6'h23;
  localparam logic [5:0] CMD_EMISS     = 6'h24;
  localparam logic [5:0] CMD_CONFIG    = 6'h25;
  localparam logic [5:0] CMD_FIXED4    = 6'h2e;
  localparam logic [5:0] CMD_FIXED5    = 6'h3c;
  localparam logic [5:0] CMD_FIXED6    = 6'h3d;
  localparam logic [5:0] CMD_FIXED7    = 6'h3e;
  localparam logic [5:0] CMD_FIXED8    = 6'h3f;

  // Reset and constant words
  localparam logic [15:0] RawCh1Rst   = 16'd37504;
  localparam logic [15:0] RawCh2Rst   = 16'd32825;
  localparam logic [15:0] AmbientRst  = 16'd14986;
  localparam logic [15:0] ObjTemp1Rst = 16'd14917;
  localparam logic [15:0] ObjTemp2Rst = 16'd14854;
  localparam logic [15:0] EmissRst    = 16'hf332;
  localparam logic [15:0] ConfigRst   = 16'hb7f0;
  localparam logic [15:0] Fixed0      = 16'h9993;
  localparam logic [15:0] Fixed1      = 16'h7c62;
  localparam logic [15:0] Fixed2      = 16'h0201;
  localparam logic [15:0] Fixed3      = 16'hf71c;
  localparam logic [15:0] Fixed4      = 16'h5abc;
  localparam logic [15:0] Fixed5      = 16'h4809;
  localparam logic [15:0] Fixed6      = 16'he196;
  localparam logic [15:0] Fixed7      = 16'h24a7;
  localparam logic [15:0] Fixed8      = 16'hc88a;
  localparam logic [15:0] Unmapped    = 16'hffff;

  localparam logic [7:0] CrcPoly = 8'h07;

  // Word write request from the protocol logic to the register file
  typedef struct packed {
    logic        en;
    logic [5:0]  cmd;
    logic [15:0] value;
  } wr_req_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- src/smbsr_regs.sv -----
// Register file of the SMBus sensor slave: sensor words set over the
// configuration port, the two guarded writable words and the read mux.
// Depends on smbsr_pkg.
module smbsr_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  smbsr_pkg::wr_req_t   wr_req_i,
  input  logic [5:0]           rd_cmd_i,
  output logic [15:0]          rd_word_o
);

  logic [15:0] raw_ch1_q, raw_ch2_q, ambient_q, obj_temp1_q, obj_temp2_q;
  logic [15:0] emiss_q, emiss_d, config_q, config_d;

  // Sensor words, written from the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_ch1_q   <= smbsr_pkg::RawCh1Rst;
      raw_ch2_q   <= smbsr_pkg::RawCh2Rst;
      ambient_q   <= smbsr_pkg::AmbientRst;
      obj_temp1_q <= smbsr_pkg::ObjTemp1Rst;
      obj_temp2_q <= smbsr_pkg::ObjTemp2Rst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        smbsr_pkg::REG_RAW_CH1:   raw_ch1_q   <= cfg_data_i;
        smbsr_pkg::REG_RAW_CH2:   raw_ch2_q   <= cfg_data_i;
        smbsr_pkg::REG_AMBIENT:   ambient_q   <= cfg_data_i;
        smbsr_pkg::REG_OBJ_TEMP1: obj_temp1_q <= cfg_data_i;
        smbsr_pkg::REG_OBJ_TEMP2: obj_temp2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Guarded writes: zero always clears, nonzero only lands on a cleared word
  always_comb begin
    emiss_d  = emiss_q;
    config_d = config_q;
    if (wr_req_i.en) begin
      if (wr_req_i.cmd == smbsr_pkg::CMD_EMISS) begin
        if (wr_req_i.value == 16'h0000 || emiss_q == 16'h0000) emiss_d = wr_req_i.value;
      end else if (wr_req_i.cmd == smbsr_pkg::CMD_CONFIG) begin
        if (wr_req_i.value == 16'h0000 || config_q == 16'h0000) config_d = wr_req_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emiss_q  <= smbsr_pkg::EmissRst;
      config_q <= smbsr_pkg::ConfigRst;
    end else begin
      emiss_q  <= emiss_d;
      config_q <= config_d;
    end
  end

  // Read mux by command code
  always_comb begin
    unique case (rd_cmd_i)
      smbsr_pkg::CMD_RAW_CH1:   rd_word_o = raw_ch1_q;
      smbsr_pkg::CMD_RAW_CH2:   rd_word_o = raw_ch2_q;
      smbsr_pkg::CMD_AMBIENT:   rd_word_o = ambient_q;
      smbsr_pkg::CMD_OBJ_TEMP1: rd_word_o = obj_temp1_q;
      smbsr_pkg::CMD_OBJ_TEMP2: rd_word_o = obj_temp2_q;
      smbsr_pkg::CMD_FIXED0:    rd_word_o = smbsr_pkg::Fixed0;
      smbsr_pkg::CMD_FIXED1:    rd_word_o = smbsr_pkg::Fixed1;
      smbsr_pkg::CMD_FIXED2:    rd_word_o = smbsr_pkg::Fixed2;
      smbsr_pkg::CMD_FIXED3:    rd_word_o = smbsr_pkg::Fixed3;
      smbsr_pkg::CMD_EMISS:     rd_word_o = emiss_q;
      smbsr_pkg::CMD_CONFIG:    rd_word_o = config_q;
      smbsr_pkg::CMD_FIXED4:    rd_word_o = smbsr_pkg::Fixed4;
      smbsr_pkg::CMD_FIXED5:    rd_word_o = smbsr_pkg::Fixed5;
      smbsr_pkg::CMD_FIXED6:    rd_word_o = smbsr_pkg::Fixed6;
      smbsr_pkg::CMD_FIXED7:    rd_word_o = smbsr_pkg::Fixed7;
      smbsr_pkg::CMD_FIXED8:    rd_word_o = smbsr_pkg::Fixed8;
      default:                  rd_word_o = smbsr_pkg::Unmapped;
    endcase
  end

endmodule

// ----- src/smbus_sensor_register_slave.sv -----
// Top level of the SMBus sensor register slave: event register, phase
// machine with PEC tracking, and result register.
// Depends on smbsr_pkg and smbsr_regs.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one bus event per beat:
//   start with address and direction, stop, written byte or read request.
//   Output channel (out_valid_o / out_stall_i) returns exactly one beat per
//   event: ack, nack or done, plus the byte driven on a read.
//   An accepted event lands in the event register and is decoded against
//   the phase, command, word buffer and PEC state combinationally; its
//   result is loaded into the result register when the event retires.
//   Throughput: one event per cycle unless the result channel stalls; the
//   phase/PEC state loop closes through one CRC-8 byte update and the
//   register read mux. Stall: while the result register holds an untaken
//   beat the event register still takes one more event; only then is
//   in_stall_o raised. Reset: phase idle, PEC and buffers cleared, sensor
//   words and the two writable words back to their reset values. Sensor
//   words must be written by the user through cfg_we_i / cfg_index_i /
//   cfg_data_i only while no event is pending; the block does not enforce it.
module smbus_sensor_register_slave (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic        direction_i,
  input  logic [6:0]  bus_address_i,
  input  logic [7:0]  write_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  response_o,
  output logic [7:0]  read_byte_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic        in_valid_q, in_valid_d;
  logic [1:0]  func_q;
  logic        dir_q;
  logic [6:0]  addr_q;
  logic [7:0]  wbyte_q;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  resp_q, resp_d;
  logic [7:0]  rbyte_q, rbyte_d;
  logic [2:0]  phase_q, phase_d;
  logic [5:0]  cmd_q, cmd_d;
  logic [15:0] wbuf_q, wbuf_d;
  logic [7:0]  pec_q, pec_d;
  logic        out_free, adv, in_acc;
  logic [15:0] rd_word;
  smbsr_pkg::wr_req_t wr_req;

  // Handshake: the event register moves on when the result register is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc)   in_valid_d = 1'b1;
    else if (adv) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_valid_q <= 1'b0;
    else         in_valid_q <= in_valid_d;
  end

  // Event payload register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q  <= func_i;
      dir_q   <= direction_i;
      addr_q  <= bus_address_i;
      wbyte_q <= write_byte_i;
    end
  end

  smbsr_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .wr_req_i    (wr_req),
    .rd_cmd_i    (cmd_q),
    .rd_word_o   (rd_word)
  );

  // Phase machine and PEC update for the event in the register
  always_comb begin
    logic [7:0] crc_w;
    phase_d = phase_q;
    cmd_d   = cmd_q;
    wbuf_d  = wbuf_q;
    pec_d   = pec_q;
    resp_d  = smbsr_pkg::RESP_ACK;
    rbyte_d = 8'h00;
    wr_req  = '{en: 1'b0, cmd: cmd_q, value: wbuf_q};
    crc_w   = smbsr_pkg::crc8_byte(pec_q, wbyte_q);
    case (func_q)
      smbsr_pkg::FN_START: begin
        if (!dir_q) begin
          phase_d = smbsr_pkg::PH_CMD;
          pec_d   = smbsr_pkg::crc8_byte(8'h00, {addr_q, 1'b0});
        end else begin
          pec_d = smbsr_pkg::crc8_byte(pec_q, {addr_q, 1'b1});
          if (phase_q != smbsr_pkg::PH_LOW) resp_d = smbsr_pkg::RESP_NACK;
        end
      end
      smbsr_pkg::FN_STOP: phase_d = smbsr_pkg::PH_IDLE;
      smbsr_pkg::FN_WRITE: begin
        case (phase_q)
          smbsr_pkg::PH_CMD: begin
            if (wbyte_q > smbsr_pkg::CmdMax) begin
              resp_d = smbsr_pkg::RESP_NACK;
            end else begin
              cmd_d   = wbyte_q[5:0];
              phase_d = smbsr_pkg::PH_LOW;
              pec_d   = crc_w;
            end
          end
          smbsr_pkg::PH_LOW: begin
            wbuf_d  = {8'h00, wbyte_q};
            phase_d = smbsr_pkg::PH_HIGH;
            pec_d   = crc_w;
          end
          smbsr_pkg::PH_HIGH: begin
            wbuf_d  = wbuf_q | {wbyte_q, 8'h00};
            phase_d = smbsr_pkg::PH_PEC;
            pec_d   = crc_w;
          end
          smbsr_pkg::PH_PEC: begin
            pec_d     = crc_w;
            wr_req.en = (crc_w == 8'h00) && adv;
          end
          default: ;
        endcase
      end
      default: begin
        // read byte request
        resp_d = smbsr_pkg::RESP_DONE;
        case (phase_q)
          smbsr_pkg::PH_LOW: begin
            wbuf_d  = rd_word;
            rbyte_d = rd_word[7:0];
            pec_d   = smbsr_pkg::crc8_byte(pec_q, rd_word[7:0]);
            phase_d = smbsr_pkg::PH_HIGH;
          end
          smbsr_pkg::PH_HIGH: begin
            rbyte_d = wbuf_q[15:8];
            pec_d   = smbsr_pkg::crc8_byte(pec_q, wbuf_q[15:8]);
            phase_d = smbsr_pkg::PH_PEC;
          end
          smbsr_pkg::PH_PEC: rbyte_d = pec_q;
          default: ;
        endcase
      end
    endcase
  end

  // Transfer state commits when the event retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= smbsr_pkg::PH_IDLE;
      cmd_q   <= 6'd0;
      wbuf_q  <= 16'h0000;
      pec_q   <= 8'h00;
    end else if (adv) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      wbuf_q  <= wbuf_d;
      pec_q   <= pec_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (adv) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      resp_q  <= resp_d;
      rbyte_q <= rbyte_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign response_o  = resp_q;
  assign read_byte_o = rbyte_q;

  // Checks
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == smbsr_pkg::PH_IDLE || phase_q == smbsr_pkg::PH_CMD ||
    phase_q == smbsr_pkg::PH_HIGH || phase_q == smbsr_pkg::PH_LOW ||
    phase_q == smbsr_pkg::PH_PEC)
    else $error("phase register left the legal codes");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("event channel stalled with a free pipeline");

  a_stop_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && func_q == smbsr_pkg::FN_STOP |=> phase_q == smbsr_pkg::PH_IDLE)
    else $error("stop did not return phase to idle");

  a_byte_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && response_o != smbsr_pkg::RESP_DONE |-> read_byte_o == 8'h00)
    else $error("byte driven on a non-read beat");

  a_write_needs_pec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req.en |-> phase_q == smbsr_pkg::PH_PEC && func_q == smbsr_pkg::FN_WRITE)
    else $error("word write outside the PEC phase");

endmodule
